>>> hdl/fha_pkg.sv
// Shared command codes and state encodings for the first-fit heap allocator.
package fha_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Fixed field widths of the stream payload
  localparam int unsigned FIELD_W = 14;

  // Sequencer state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_A_CHK = 3'd1;
  localparam logic [2:0] ST_A_WR2 = 3'd2;
  localparam logic [2:0] ST_F_RD  = 3'd3;
  localparam logic [2:0] ST_M_ST  = 3'd4;
  localparam logic [2:0] ST_M_C   = 3'd5;
  localparam logic [2:0] ST_M_N   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

endpackage

>>> hdl/fha_mem.sv
// Header memory: one write port, one read port, registered read data.
module fha_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned DW    = 29
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DW-1:0]            wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DW-1:0]            rd_data_o
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

>>> hdl/fha_ctrl.sv
// Sequencer: walks the header chain for allocate, free and merge.
module fha_ctrl #(
  parameter int unsigned ARENA_BYTES  = 16384,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          req_cmd_i,
  input  logic [fha_pkg::FIELD_W-1:0]   req_size_i,
  input  logic [fha_pkg::FIELD_W-1:0]   req_addr_i,
  // result
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          res_ok_o,
  output logic [fha_pkg::FIELD_W-1:0]   res_off_o,
  // memory
  output logic                          wr_en_o,
  output logic [$clog2(ARENA_BYTES)-1:0] wr_addr_o,
  output logic [2*$clog2(ARENA_BYTES):0] wr_data_o,
  output logic [$clog2(ARENA_BYTES)-1:0] rd_addr_o,
  input  logic [2*$clog2(ARENA_BYTES):0] rd_data_i
);
  import fha_pkg::*;

  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned CW = ((AW > FIELD_W) ? AW : FIELD_W) + 2;

  logic [2:0]         state_q, state_d;
  logic               init_q, init_d;
  logic [AW-1:0]      raddr_q;
  logic [AW-1:0]      cur_q, cur_d;
  logic [AW-1:0]      nxt_q, nxt_d;
  logic [AW-1:0]      hsize_q, hsize_d;
  logic [AW-1:0]      hnext_q, hnext_d;
  logic               hfree_q, hfree_d;
  logic [FIELD_W-1:0] req_q, req_d;
  logic [AW-1:0]      fh_q, fh_d;
  logic               rok_q, rok_d;
  logic [FIELD_W-1:0] roff_q, roff_d;
  logic               ovalid_q, ovalid_d;
  logic               ook_q;
  logic [FIELD_W-1:0] ooff_q;
  logic               load;

  // decoded read data; entry zero reads as one whole free block until written
  logic [AW-1:0] d_size, d_next;
  logic          d_free;
  logic [CW-1:0] size_w, req_w, hdr_w, fh_w, nb_w, cur_w, merged_w;

  always_comb begin
    if (raddr_q == '0 && !init_q) begin
      d_size = AW'(ARENA_BYTES - HEADER_BYTES);
      d_next = '0;
      d_free = 1'b1;
    end else begin
      d_size = rd_data_i[AW-1:0];
      d_next = rd_data_i[2*AW-1:AW];
      d_free = rd_data_i[2*AW];
    end
  end

  assign size_w   = CW'(d_size);
  assign req_w    = CW'(req_q);
  assign hdr_w    = CW'(HEADER_BYTES);
  assign cur_w    = CW'(cur_q);
  assign nb_w     = cur_w + hdr_w + req_w;
  assign fh_w     = CW'(req_addr_i) - hdr_w;
  assign merged_w = CW'(hsize_q) + hdr_w + size_w;

  // next-state and memory control
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    nxt_d    = nxt_q;
    hsize_d  = hsize_q;
    hnext_d  = hnext_q;
    hfree_d  = hfree_q;
    req_d    = req_q;
    fh_d     = fh_q;
    rok_d    = rok_q;
    roff_d   = roff_q;
    wr_en_o  = 1'b0;
    wr_addr_o = cur_q;
    wr_data_o = {d_free, d_next, d_size};
    rd_addr_o = '0;
    load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d  = req_size_i;
          rok_d  = 1'b0;
          roff_d = '0;
          cur_d  = '0;
          if (req_cmd_i == CMD_ALLOC) begin
            state_d = (req_size_i == '0) ? ST_FIN : ST_A_CHK;
          end else if (CW'(req_addr_i) < hdr_w) begin
            state_d = ST_FIN;
          end else if (fh_w < CW'(ARENA_BYTES)) begin
            fh_d      = fh_w[AW-1:0];
            rd_addr_o = fh_w[AW-1:0];
            state_d   = ST_F_RD;
          end else begin
            state_d = ST_M_C;
          end
        end
      end
      ST_A_CHK: begin
        if (d_free && size_w >= req_w) begin
          rok_d  = 1'b1;
          roff_d = FIELD_W'(cur_w + hdr_w);
          wr_en_o = 1'b1;
          if (size_w >= req_w + hdr_w + CW'(1) && nb_w < CW'(ARENA_BYTES)) begin
            wr_addr_o = nb_w[AW-1:0];
            wr_data_o = {1'b1, d_next, AW'(size_w - req_w - hdr_w)};
            nxt_d     = nb_w[AW-1:0];
            state_d   = ST_A_WR2;
          end else begin
            wr_data_o = {1'b0, d_next, d_size};
            state_d   = ST_FIN;
          end
        end else if (d_next == '0) begin
          state_d = ST_FIN;
        end else begin
          rd_addr_o = d_next;
          cur_d     = d_next;
        end
      end
      ST_A_WR2: begin
        wr_en_o   = 1'b1;
        wr_data_o = {1'b0, nxt_q, AW'(req_q)};
        state_d   = ST_FIN;
      end
      ST_F_RD: begin
        wr_en_o   = 1'b1;
        wr_addr_o = fh_q;
        wr_data_o = {1'b1, d_next, d_size};
        state_d   = ST_M_ST;
      end
      ST_M_ST: begin
        cur_d   = '0;
        state_d = ST_M_C;
      end
      ST_M_C: begin
        rok_d   = 1'b1;
        hsize_d = d_size;
        hnext_d = d_next;
        hfree_d = d_free;
        if (d_next == '0) begin
          state_d = ST_FIN;
        end else begin
          rd_addr_o = d_next;
          nxt_d     = d_next;
          state_d   = ST_M_N;
        end
      end
      ST_M_N: begin
        if (hfree_q && d_free) begin
          // absorb the next block into the current one
          hsize_d   = merged_w[AW-1:0];
          hnext_d   = d_next;
          wr_en_o   = 1'b1;
          wr_addr_o = cur_q;
          wr_data_o = {1'b1, d_next, merged_w[AW-1:0]};
        end else begin
          cur_d   = nxt_q;
          hsize_d = d_size;
          hnext_d = d_next;
          hfree_d = d_free;
        end
        if (d_next == '0) begin
          state_d = ST_FIN;
        end else begin
          rd_addr_o = d_next;
          nxt_d     = d_next;
        end
      end
      ST_FIN: begin
        if (!ovalid_q || res_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign init_d   = init_q || (wr_en_o && wr_addr_o == '0);
  assign ovalid_d = load || (ovalid_q && !res_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      init_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      ovalid_q <= ovalid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    raddr_q <= rd_addr_o;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    hsize_q <= hsize_d;
    hnext_q <= hnext_d;
    hfree_q <= hfree_d;
    req_q   <= req_d;
    fh_q    <= fh_d;
    rok_q   <= rok_d;
    roff_q  <= roff_d;
    if (load) begin
      ook_q  <= rok_q;
      ooff_q <= roff_q;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = ovalid_q;
  assign res_ok_o    = ook_q;
  assign res_off_o   = ooff_q;

  // a merge write never targets the entry fetched next along the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_o && state_q == ST_M_N && d_next != '0) |-> (wr_addr_o != rd_addr_o))
    else $error("merge write collides with read");

  // no memory write while waiting for a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_en_o)
    else $error("memory write while idle");

  // entry zero, once written, stays backed by memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |=> init_q)
    else $error("entry zero init flag dropped");

  // a result is loaded only from the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result loaded outside finish");

endmodule

>>> hdl/first_fit_heap_allocator.sv
// First-fit heap allocator top level: stream ports, sequencer and header memory.
// Throughput: one item at a time, set by the walk of one header per cycle
//   through the single read port of the header memory.
// Reset: asynchronous, active low; the arena is one free block at once.
module first_fit_heap_allocator #(
  parameter int unsigned ARENA_BYTES  = 16384,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // request_size[13:0], block_address[27:14], zero pad
  input  logic        s_axis_tuser_i,  // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // user_offset[13:0], zero pad
  output logic        m_axis_tuser_o   // ok
);
  import fha_pkg::*;

  localparam int unsigned AW = $clog2(ARENA_BYTES);

  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [2*AW:0]      wr_data, rd_data;
  logic [FIELD_W-1:0] res_off;

  fha_ctrl #(
    .ARENA_BYTES (ARENA_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .req_cmd_i  (s_axis_tuser_i),
    .req_size_i (s_axis_tdata_i[13:0]),
    .req_addr_i (s_axis_tdata_i[27:14]),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_ok_o   (m_axis_tuser_o),
    .res_off_o  (res_off),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  fha_mem #(
    .DEPTH(ARENA_BYTES),
    .DW   (2 * AW + 1)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign m_axis_tdata_o = {2'b00, res_off};

endmodule

>>> sim/tb.sv
// Testbench for the first-fit heap allocator: directed table, then random alloc/free traffic.
`timescale 1ns / 1ps

module tb;
  import fha_pkg::*;

  localparam int unsigned ARENA  = 16384;
  localparam int unsigned HDR    = 24;
  localparam int unsigned NRAND  = 2000;
  localparam longint      LIMIT  = 10000000;

  typedef struct packed {
    logic                cmd;
    logic [FIELD_W-1:0]  size;
    logic [FIELD_W-1:0]  addr;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [FIELD_W-1:0]  offset;
  } grant_t;

  // directed row: request plus optional hand-typed expectation
  typedef struct packed {
    req_t   rq;
    logic   typed;
    grant_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  always #5 clk_i = ~clk_i;

  first_fit_heap_allocator u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // heap shadow
  int unsigned blk_size [ARENA];
  int unsigned blk_next [ARENA];
  bit          blk_free [ARENA];

  grant_t      grants_due[$];
  int unsigned live_offsets[$];
  int          mismatches = 0;
  longint      cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic void heap_reset();
    for (int i = 0; i < ARENA; i++) begin
      blk_size[i] = 0; blk_next[i] = 0; blk_free[i] = 0;
    end
    blk_size[0] = ARENA - HDR;
    blk_free[0] = 1;
  endfunction

  function automatic void coalesce();
    int unsigned cur, nxt, guard;
    cur = 0; guard = 0;
    while (cur < ARENA && guard < ARENA) begin
      nxt = blk_next[cur];
      guard++;
      if (nxt == 0 || nxt >= ARENA) break;
      if (blk_free[cur] && blk_free[nxt]) begin
        blk_size[cur] += HDR + blk_size[nxt];
        blk_next[cur] = blk_next[nxt];
      end else begin
        cur = nxt;
      end
    end
  endfunction

  function automatic grant_t heap_apply(req_t rq);
    grant_t g;
    int unsigned cur, guard, nb, want;
    g = '0;
    want = rq.size;
    if (rq.cmd == CMD_ALLOC) begin
      if (want != 0) begin
        cur = 0; guard = 0;
        while (cur < ARENA && guard < ARENA) begin
          guard++;
          if (blk_free[cur] && blk_size[cur] >= want) begin
            if (blk_size[cur] >= want + HDR + 1) begin
              nb = cur + HDR + want;
              if (nb < ARENA) begin
                blk_size[nb] = blk_size[cur] - want - HDR;
                blk_free[nb] = 1;
                blk_next[nb] = blk_next[cur];
                blk_size[cur] = want;
                blk_next[cur] = nb;
              end
            end
            blk_free[cur] = 0;
            g.ok = 1'b1;
            g.offset = FIELD_W'(cur + HDR);
            break;
          end
          cur = blk_next[cur];
          if (cur == 0) break;
        end
      end
    end else if (rq.addr != 0 && rq.addr >= HDR) begin
      blk_free[rq.addr - HDR] = 1;
      coalesce();
      g.ok = 1'b1;
    end
    return g;
  endfunction

  // drive one request and queue its expectation; valid stays up for the next item
  task automatic send_request(req_t rq, bit typed, grant_t want);
    grant_t g;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= rq.cmd;
    s_axis_tdata_i  <= {4'b0, rq.addr, rq.size};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    g = heap_apply(rq);
    if (typed && g != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: typed %h predicted %h", want, g);
    end
    grants_due.push_back(g);
    if (rq.cmd == CMD_ALLOC && g.ok) live_offsets.push_back(g.offset);
  endtask

  task automatic drain();
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver: stalls and result checking
  always @(posedge clk_i) begin
    grant_t got, exp_g;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.ok = m_axis_tuser_o;
      got.offset = m_axis_tdata_o[FIELD_W-1:0];
      if (grants_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result ok=%0d off=%0d", got.ok, got.offset);
      end else begin
        exp_g = grants_due.pop_front();
        if (got.ok !== exp_g.ok || got.offset !== exp_g.offset ||
            m_axis_tdata_o[15:FIELD_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected ok=%0d off=%0d, got ok=%0d off=%0d",
                     exp_g.ok, exp_g.offset, got.ok, got.offset);
        end
      end
    end
    m_axis_tready_i <= !hold_off &&
                       !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted in its own process
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  // directed table
  row_t dir_rows[] = '{
    '{'{CMD_ALLOC, 14'd0, 14'd0}, 1'b1, '{1'b0, 14'd0}},
    '{'{CMD_ALLOC, 14'd16383, 14'd0}, 1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE, 14'd0, 14'd0}, 1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE, 14'd16383, 14'd23}, 1'b1, '{1'b0, 14'd0}},
    '{'{CMD_ALLOC, 14'd1, 14'd16383}, 1'b1, '{1'b1, 14'd24}},
    '{'{CMD_ALLOC, 14'd100, 14'd0}, 1'b1, '{1'b1, 14'd49}},
    '{'{CMD_ALLOC, 14'd50, 14'd0}, 1'b0, '0},
    '{'{CMD_FREE, 14'd0, 14'd49}, 1'b1, '{1'b1, 14'd0}},
    '{'{CMD_FREE, 14'd0, 14'd49}, 1'b1, '{1'b1, 14'd0}},
    '{'{CMD_ALLOC, 14'd90, 14'd0}, 1'b0, '0},
    '{'{CMD_FREE, 14'd0, 14'd50}, 1'b0, '0},
    '{'{CMD_FREE, 14'd0, 14'd16383}, 1'b0, '0},
    '{'{CMD_ALLOC, 14'd16000, 14'd0}, 1'b0, '0},
    '{'{CMD_ALLOC, 14'd16383, 14'd0}, 1'b1, '{1'b0, 14'd0}},
    '{'{CMD_FREE, 14'd0, 14'd24}, 1'b0, '0},
    '{'{CMD_ALLOC, 14'd10, 14'd0}, 1'b0, '0},
    '{'{CMD_FREE, 14'd0, 14'd24}, 1'b1, '{1'b1, 14'd0}}
  };

  // one random request, mostly well-formed traffic over a live set
  task automatic random_request();
    req_t rq;
    int   pick, idx;
    rq = '0;
    pick = $urandom_range(99);
    if (pick < 50) begin
      rq.cmd = CMD_ALLOC;
      rq.size = ($urandom_range(9) == 0) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(1, 600));
      rq.addr = FIELD_W'($urandom);
    end else if (pick < 90 && live_offsets.size() != 0) begin
      rq.cmd = CMD_FREE;
      idx = $urandom_range(live_offsets.size() - 1);
      rq.addr = FIELD_W'(live_offsets[idx]);
      live_offsets.delete(idx);
      rq.size = FIELD_W'($urandom);
    end else begin
      rq.cmd = CMD_FREE;
      rq.addr = ($urandom_range(1) == 0) ? FIELD_W'($urandom_range(0, 30)) : FIELD_W'($urandom);
      rq.size = FIELD_W'($urandom);
    end
    send_request(rq, 1'b0, '0);
  endtask

  initial begin
    heap_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

    // back-pressure: block fills and stalls its input
    fork
      long_hold();
      repeat (20) random_request();
    join

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (NRAND / 4) random_request();
    end
    s_axis_tvalid_i <= 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
